// ===== sv/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// chr_pkg: shared types and constants of the chromaticity histogram
// Holds the sRGB linearization table, the queue entry and the back status.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int unsigned HalfSqrt3Q16 = 56756;
  localparam logic [7:0]  BinResetVal  = 8'd100;
  localparam logic [7:0]  BinMaxVal    = 8'd255;

  typedef logic [255:0][15:0] lut_t;

  // Queue entry: one classified item
  typedef struct packed {
    logic        rd;     // read request
    logic [17:0] s;      // B+G+R, linear
    logic [16:0] bg;     // B+G, linear
    logic [17:0] gr2;    // 2G+R, linear
    logic [7:0]  row;    // read row
    logic [8:0]  col;    // read column
  } entry_t;

  // Back part status toward the front and the top
  typedef struct packed {
    logic clearing;
  } back_sts_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MUL2,
    ST_DIV,
    ST_CHK,
    ST_RD,
    ST_UPD
  } back_state_e;

  function automatic longint unsigned pow5_q24(longint unsigned r);
    longint unsigned r2;
    longint unsigned r4;
    r2 = (r * r) >> 24;
    r4 = (r2 * r2) >> 24;
    return (r4 * r) >> 24;
  endfunction

  // One linearization entry, Q16 fraction
  function automatic logic [15:0] lin_entry(int unsigned v);
    longint unsigned n;
    longint unsigned big_t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned lin;
    if (v <= 10) begin
      lin = (longint'(v) * 64'd6553600 + 64'd164730) / 64'd329460;
      return lin[15:0];
    end
    n     = 64'd1000 * longint'(v) + 64'd14025;
    big_t = (n << 24) / 64'd269025;
    t2    = (big_t * big_t) >> 24;
    lo    = 0;
    hi    = 64'd1 << 24;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5_q24(mid) <= t2) lo = mid;
      else hi = mid - 64'd1;
    end
    lin = (((t2 * lo) >> 24) + 64'd128) >> 8;
    if (lin > 64'd65535) lin = 64'd65535;
    return lin[15:0];
  endfunction

  function automatic lut_t build_lut();
    lut_t t;
    for (int unsigned i = 0; i < 256; i++) t[i] = lin_entry(i);
    return t;
  endfunction

  localparam lut_t LinLut = build_lut();

endpackage

// ===== sv/chromaticity_histogram.sv =====
// ----------------------------------------------------------------------------
// chromaticity_histogram: Maxwell-triangle histogram of BGR pixels
// Accumulates pixels into ROWS x COLS 8-bit bins and reads bins back.
// ----------------------------------------------------------------------------
// Steps from input transfer to result valid: read items take the queue pop, the
//   RAM read and the result update; pixels take the queue pop, two multiply steps,
//   the division (one quotient bit per cycle), range check, RAM read-modify-write.
// Sequencing: one item in flight in the back sequencer; the next item is popped
//   the cycle after the result transfer.
// Reset: asynchronous; afterwards a clearing pass writes 100 to all ROWS*COLS
//   bins, one per cycle, and no item is taken until it ends.
module chromaticity_histogram #(
  parameter int unsigned SCALE      = 256,
  parameter int unsigned ROWS       = 230,
  parameter int unsigned COLS       = 260,
  parameter int unsigned ROW_OFFSET = 4,
  parameter int unsigned COL_OFFSET = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // func
  input  logic [47:0] s_axis_tdata,   // blue[7:0], green, red, read_row, read_col[40:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,   // placed
  output logic [31:0] m_axis_tdata    // bin_row[7:0], bin_col[16:8], count[24:17]
);
  import chr_pkg::*;

  back_sts_t sts;
  entry_t    f_entry, b_entry;
  logic      push, pop, q_full, q_empty;

  chr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .sts_i         (sts),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (f_entry)
  );

  chr_fifo #(
    .W ($bits(entry_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (f_entry),
    .pop_i   (pop),
    .rdata_o (b_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  chr_back #(
    .SCALE      (SCALE),
    .ROWS       (ROWS),
    .COLS       (COLS),
    .ROW_OFFSET (ROW_OFFSET),
    .COL_OFFSET (COL_OFFSET)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (b_entry),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  // No intake during the clearing pass
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.clearing |-> !s_axis_tready)
    else $error("item taken during bin clearing");

  // A result never appears straight out of the clearing pass
  a_no_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(sts.clearing))
    else $error("result raised during bin clearing");

  // An unplaced result carries zero fields
  a_unplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("unplaced result with nonzero fields");

  // The queue is never popped while empty
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

// ===== sv/chr_ram.sv =====
// ----------------------------------------------------------------------------
// chr_ram: generic single-write, single-read RAM
// Registered read data, valid in the cycle after the address.
// ----------------------------------------------------------------------------
module chr_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/chr_fifo.sv =====
// ----------------------------------------------------------------------------
// chr_fifo: two-entry queue between front and back
// Decouples item intake from bin processing.
// ----------------------------------------------------------------------------
module chr_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

endmodule

// ===== sv/chr_front.sv =====
// ----------------------------------------------------------------------------
// chr_front: item intake and classification
// Linearizes the pixel channels and forms the sums for the back part.
// ----------------------------------------------------------------------------
module chr_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              s_axis_tuser,   // func
  input  logic [47:0]       s_axis_tdata,   // blue, green, red, read_row, read_col
  input  chr_pkg::back_sts_t sts_i,
  input  logic              q_full_i,
  output logic              push_o,
  output chr_pkg::entry_t   entry_o
);
  import chr_pkg::*;

  logic [15:0] lin_b, lin_g, lin_r;

  // Linearize channels
  assign lin_b = LinLut[s_axis_tdata[7:0]];
  assign lin_g = LinLut[s_axis_tdata[15:8]];
  assign lin_r = LinLut[s_axis_tdata[23:16]];

  // Build the queue entry
  always_comb begin
    entry_o.rd  = s_axis_tuser;
    entry_o.s   = 18'(lin_b) + 18'(lin_g) + 18'(lin_r);
    entry_o.bg  = 17'(lin_b) + 17'(lin_g);
    entry_o.gr2 = {1'b0, lin_g, 1'b0} + 18'(lin_r);
    entry_o.row = s_axis_tdata[31:24];
    entry_o.col = s_axis_tdata[40:32];
  end

  // Hold off while the bins are cleared or the queue is full
  assign s_axis_tready = !q_full_i && !sts_i.clearing;
  assign push_o        = s_axis_tvalid && s_axis_tready;

endmodule

// ===== sv/chr_back.sv =====
// ----------------------------------------------------------------------------
// chr_back: bin mapping and count update
// Divides for row and column, range checks, and updates or reads back the bin RAM.
// ----------------------------------------------------------------------------
module chr_back #(
  parameter int unsigned SCALE      = 256,
  parameter int unsigned ROWS       = 230,
  parameter int unsigned COLS       = 260,
  parameter int unsigned ROW_OFFSET = 4,
  parameter int unsigned COL_OFFSET = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  chr_pkg::entry_t    entry_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output chr_pkg::back_sts_t sts_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic               m_axis_tuser,  // placed
  output logic [31:0]        m_axis_tdata   // bin_row, bin_col, count
);
  import chr_pkg::*;

  localparam int unsigned Depth = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned QW    = $clog2(SCALE + 1);
  localparam int unsigned CTW   = $clog2(QW);
  localparam int unsigned RW    = 35 + QW;
  localparam int unsigned CW    = 20 + QW;
  localparam int unsigned KW    = QW + 6;

  back_state_e state_q, state_d;
  entry_t         e_q;
  logic [AW-1:0]  addr_q;
  logic [32:0]    prod_q;
  logic [RW-1:0]  remr_q, trialr;
  logic [CW-1:0]  remc_q, trialc;
  logic [QW-1:0]  qr_q, qc_q;
  logic [CTW-1:0] cnt_q;
  logic [7:0]     row_q;
  logic [8:0]     col_q;
  logic           out_valid_q, out_placed_q;
  logic [7:0]     out_row_q, out_cnt_q;
  logic [8:0]     out_col_q;
  logic           rd_ok, bin_ok;
  logic [KW-1:0]  rowv, colv;
  logic [AW-1:0]  rd_addr, bin_addr;
  logic           ram_we;
  logic [7:0]     ram_wdata, ram_rdata, inc_cnt;

  // Range checks and bin addresses
  assign rd_ok    = (KW'(entry_i.row) < KW'(ROWS)) && (KW'(entry_i.col) < KW'(COLS));
  assign rd_addr  = AW'(AW'(entry_i.row) * AW'(COLS) + AW'(entry_i.col));
  assign rowv     = KW'(qr_q) + KW'(ROW_OFFSET);
  assign colv     = KW'(qc_q) + KW'(COL_OFFSET);
  assign bin_ok   = (rowv < KW'(ROWS)) && (colv < KW'(COLS));
  assign bin_addr = AW'(AW'(rowv) * AW'(COLS) + AW'(colv));
  assign trialr   = RW'({e_q.s, 16'b0}) << cnt_q;
  assign trialc   = CW'({e_q.s, 1'b0}) << cnt_q;
  assign inc_cnt  = (ram_rdata == BinMaxVal) ? BinMaxVal : ram_rdata + 8'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (addr_q == AW'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pop_o) begin
          if (entry_i.rd) state_d = rd_ok ? ST_RD : ST_IDLE;
          else state_d = (entry_i.s == '0) ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_CHK;
      ST_CHK:  state_d = bin_ok ? ST_RD : ST_IDLE;
      ST_RD:   state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o          = (state_q == ST_IDLE) && !q_empty_i && !out_valid_q;
    sts_o.clearing = state_q == ST_CLEAR;
    ram_we         = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && !e_q.rd);
    ram_wdata      = (state_q == ST_CLEAR) ? BinResetVal : inc_cnt;
  end

  // Datapath and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      addr_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_placed_q <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_cnt_q    <= '0;
      e_q          <= '0;
      prod_q       <= '0;
      remr_q       <= '0;
      remc_q       <= '0;
      qr_q         <= '0;
      qc_q         <= '0;
      row_q        <= '0;
      col_q        <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: addr_q <= addr_q + AW'(1);
        ST_IDLE: begin
          if (pop_o) begin
            e_q   <= entry_i;
            row_q <= entry_i.row;
            col_q <= entry_i.col;
            if (entry_i.rd) addr_q <= rd_addr;
            if ((entry_i.rd && !rd_ok) || (!entry_i.rd && entry_i.s == '0)) begin
              out_valid_q  <= 1'b1;
              out_placed_q <= 1'b0;
              out_row_q    <= '0;
              out_col_q    <= '0;
              out_cnt_q    <= '0;
            end
          end
        end
        ST_MUL: prod_q <= 33'(HalfSqrt3Q16) * 33'(e_q.bg);
        ST_MUL2: begin
          remr_q <= RW'(prod_q) * RW'(SCALE);
          remc_q <= CW'(e_q.gr2) * CW'(SCALE);
          qr_q   <= '0;
          qc_q   <= '0;
          cnt_q  <= CTW'(QW - 1);
        end
        ST_DIV: begin
          // One quotient bit per cycle for row and column
          if (remr_q >= trialr) begin
            remr_q <= remr_q - trialr;
            qr_q   <= {qr_q[QW-2:0], 1'b1};
          end else begin
            qr_q <= {qr_q[QW-2:0], 1'b0};
          end
          if (remc_q >= trialc) begin
            remc_q <= remc_q - trialc;
            qc_q   <= {qc_q[QW-2:0], 1'b1};
          end else begin
            qc_q <= {qc_q[QW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - CTW'(1);
        end
        ST_CHK: begin
          row_q <= rowv[7:0];
          col_q <= colv[8:0];
          if (bin_ok) begin
            addr_q <= bin_addr;
          end else begin
            out_valid_q  <= 1'b1;
            out_placed_q <= 1'b0;
            out_row_q    <= '0;
            out_col_q    <= '0;
            out_cnt_q    <= '0;
          end
        end
        ST_RD: ;
        ST_UPD: begin
          out_valid_q  <= 1'b1;
          out_placed_q <= 1'b1;
          out_row_q    <= row_q;
          out_col_q    <= col_q;
          out_cnt_q    <= e_q.rd ? ram_rdata : inc_cnt;
        end
        default: ;
      endcase
    end
  end

  chr_ram #(
    .W (8),
    .D (Depth)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_placed_q;
  assign m_axis_tdata  = {7'b0, out_cnt_q, out_col_q, out_row_q};

endmodule
